// ===== rtl/core/e2c_pkg.sv =====
package e2c_pkg;

  // Face size in texels and fixed-point angle constants (Q16 radians)
  localparam int FACE_TEXELS = 1024;
  localparam int FX_ONE     = 65536;
  localparam int FX_PI      = 205887;
  localparam int FX_HALF_PI = 102944;
  localparam int FX_TWO_PI  = 411775;
  localparam int SIZE_MAX   = 16384;
  localparam int SQRT_STEPS = 17;
  localparam int CORDIC_STEPS = 16;

  // Reciprocals for the normalizing divides, scaled by 2^39
  localparam logic [22:0] RECIP_U = 23'((64'd1 << 39) / FX_TWO_PI);
  localparam logic [22:0] RECIP_V = 23'((64'd1 << 39) / FX_PI);

  // Configuration register indexes
  localparam logic REG_SOURCE_WIDTH  = 1'b0;
  localparam logic REG_SOURCE_HEIGHT = 1'b1;

  // One vector of a CORDIC in flight
  typedef struct packed {
    logic signed [27:0] a;
    logic signed [27:0] b;
    logic signed [19:0] ang;
  } vec_t;

  // Square-root chain stage contents
  typedef struct packed {
    logic               vld;
    logic               face_ok;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic [33:0]        n;
    logic [17:0]        rem;
    logic [16:0]        root;
  } sq_stage_t;

  // CORDIC chain stage contents: longitude and latitude vectors
  typedef struct packed {
    logic vld;
    logic face_ok;
    vec_t th;
    vec_t ph;
  } cd_stage_t;

  // atan(2^-i) in Q16, rounded
  function automatic logic signed [19:0] atan_tab(input logic [3:0] i);
    logic signed [19:0] t;
    case (i)
      4'd0:  t = 20'sd51472;
      4'd1:  t = 20'sd30386;
      4'd2:  t = 20'sd16055;
      4'd3:  t = 20'sd8150;
      4'd4:  t = 20'sd4091;
      4'd5:  t = 20'sd2047;
      4'd6:  t = 20'sd1024;
      4'd7:  t = 20'sd512;
      4'd8:  t = 20'sd256;
      4'd9:  t = 20'sd128;
      4'd10: t = 20'sd64;
      4'd11: t = 20'sd32;
      4'd12: t = 20'sd16;
      4'd13: t = 20'sd8;
      4'd14: t = 20'sd4;
      4'd15: t = 20'sd2;
      default: t = 20'sd0;
    endcase
    return t;
  endfunction

  // Texel centre on the face in Q16, index clamped to the face edge
  function automatic logic [17:0] centre_coord(input logic [9:0] idx);
    logic [31:0] c;
    logic [31:0] t;
    c = (32'(idx) >= 32'(FACE_TEXELS)) ? 32'(FACE_TEXELS - 1) : 32'(idx);
    t = ((c << 1) + 32'd1) << 16;
    return 18'(t / FACE_TEXELS);
  endfunction

  // Pre-rotation into the right half plane
  function automatic vec_t cordic_start(input logic signed [27:0] b,
                                        input logic signed [27:0] a);
    vec_t v;
    v.a = a;
    v.b = b;
    v.ang = '0;
    if (a < 0) begin
      v.ang = (b >= 0) ? 20'(FX_PI) : -20'(FX_PI);
      v.a = -a;
      v.b = -b;
    end
    return v;
  endfunction

  // One vectoring iteration
  function automatic vec_t cordic_iter(input vec_t v, input logic [3:0] i);
    vec_t r;
    logic signed [27:0] da;
    logic signed [27:0] db;
    da = v.b >>> i;
    db = v.a >>> i;
    if (v.b < 0) begin
      r.a = v.a - da;
      r.b = v.b + db;
      r.ang = v.ang - atan_tab(i);
    end else begin
      r.a = v.a + da;
      r.b = v.b - db;
      r.ang = v.ang + atan_tab(i);
    end
    return r;
  endfunction

  // Effective image size: zero acts as one, large values saturate
  function automatic logic [14:0] eff_size(input logic [14:0] s);
    logic [14:0] e;
    if (s == '0) begin
      e = 15'd1;
    end else if (32'(s) > SIZE_MAX) begin
      e = 15'(SIZE_MAX);
    end else begin
      e = s;
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/e2c_sqrt_cell.sv =====
module e2c_sqrt_cell
  import e2c_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  sq_stage_t d,
  output sq_stage_t q
);

  sq_stage_t q_r, q_nxt;
  logic [19:0] rem2;
  logic [19:0] trial;

  // One result bit per cell: bring down two radicand bits, try subtract
  always_comb begin
    rem2  = {d.rem, d.n[33:32]};
    trial = {1'b0, d.root, 2'b01};
    q_nxt = d;
    q_nxt.n = {d.n[31:0], 2'b00};
    if (rem2 >= trial) begin
      q_nxt.rem  = 18'(rem2 - trial);
      q_nxt.root = {d.root[15:0], 1'b1};
    end else begin
      q_nxt.rem  = rem2[17:0];
      q_nxt.root = {d.root[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/e2c_cordic_cell.sv =====
module e2c_cordic_cell
  import e2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [3:0] stage,
  input  cd_stage_t  d,
  output cd_stage_t  q
);

  cd_stage_t q_r, q_nxt;

  // Same iteration on the longitude and latitude vectors
  always_comb begin
    q_nxt = d;
    q_nxt.th = cordic_iter(d.th, stage);
    q_nxt.ph = cordic_iter(d.ph, stage);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/equirect_to_cubemap_address.sv =====
// Throughput: one transaction per cycle; a 17-cell square-root chain and a
// 16-cell CORDIC chain, each cell one iteration, set the depth.
// Back pressure on out_tready stalls the whole pipeline in place.
// Reset (rst_n low, synchronous) empties the pipeline and sets the source
// size to 2048 x 1024.
module equirect_to_cubemap_address
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // face[2:0], dest_row[12:3], dest_column[22:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // source_x[13:0], source_y[27:14],
                                  // source_byte_offset[57:28]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  logic adv;
  logic [14:0] w_r, h_r;

  // Global advance: move when the output register is free or being taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Configuration registers, stored as effective sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 15'd2048;
      h_r <= 15'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  w_r <= eff_size(cfg_data);
        REG_SOURCE_HEIGHT: h_r <= eff_size(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage 1: face coordinates
  logic [2:0] face;
  logic signed [18:0] u_w, v_w;
  logic signed [17:0] u, v, x_nxt, y_nxt, z_nxt;
  logic ok_nxt;

  assign face = in_tdata[2:0];
  assign u_w = $signed({1'b0, centre_coord(in_tdata[22:13])}) - 19'sd65536;
  assign v_w = 19'sd65536 - $signed({1'b0, centre_coord(in_tdata[12:3])});
  assign u = u_w[17:0];
  assign v = v_w[17:0];

  always_comb begin
    ok_nxt = 1'b1;
    x_nxt = '0;
    y_nxt = '0;
    z_nxt = '0;
    case (face)
      3'd0: begin x_nxt = 18'(FX_ONE);  y_nxt = v; z_nxt = -u; end
      3'd1: begin x_nxt = -18'(FX_ONE); y_nxt = v; z_nxt = u;  end
      3'd2: begin x_nxt = u; y_nxt = 18'(FX_ONE);  z_nxt = -v; end
      3'd3: begin x_nxt = u; y_nxt = -18'(FX_ONE); z_nxt = v;  end
      3'd4: begin x_nxt = u;  y_nxt = v; z_nxt = 18'(FX_ONE);  end
      3'd5: begin x_nxt = -u; y_nxt = v; z_nxt = -18'(FX_ONE); end
      default: ok_nxt = 1'b0;
    endcase
  end

  logic s1_vld_r, s1_ok_r;
  logic signed [17:0] s1_x_r, s1_y_r, s1_z_r;
  logic s2_vld_r, s2_ok_r;
  logic signed [17:0] s2_x_r, s2_y_r, s2_z_r;
  logic signed [35:0] xx_full, zz_full;
  logic [33:0] s2_xx_r, s2_zz_r;

  assign xx_full = s1_x_r * s1_x_r;
  assign zz_full = s1_z_r * s1_z_r;

  // Square-root chain
  sq_stage_t sq_in;
  sq_stage_t sq_q [SQRT_STEPS];

  always_comb begin
    sq_in.vld     = s2_vld_r;
    sq_in.face_ok = s2_ok_r;
    sq_in.x       = s2_x_r;
    sq_in.y       = s2_y_r;
    sq_in.z       = s2_z_r;
    sq_in.n       = s2_xx_r + s2_zz_r;
    sq_in.rem     = '0;
    sq_in.root    = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    e2c_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d     ((k == 0) ? sq_in : sq_q[(k == 0) ? 0 : k - 1]),
      .q     (sq_q[k])
    );
  end

  // CORDIC start: longitude atan2(x, z), latitude atan2(y, r)
  cd_stage_t cd_in_r, cd_in_nxt;
  cd_stage_t cd_q [CORDIC_STEPS];
  sq_stage_t sq_last;

  assign sq_last = sq_q[SQRT_STEPS - 1];

  always_comb begin
    cd_in_nxt.vld     = sq_last.vld;
    cd_in_nxt.face_ok = sq_last.face_ok;
    cd_in_nxt.th = cordic_start({{2{sq_last.x[17]}}, sq_last.x, 8'b0},
                                {{2{sq_last.z[17]}}, sq_last.z, 8'b0});
    cd_in_nxt.ph = cordic_start({{2{sq_last.y[17]}}, sq_last.y, 8'b0},
                                {3'b0, sq_last.root, 8'b0});
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    e2c_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .stage (4'(k)),
      .d     ((k == 0) ? cd_in_r : cd_q[(k == 0) ? 0 : k - 1]),
      .q     (cd_q[k])
    );
  end

  // Post stages: clamp, normalize, scale, wrap, address
  cd_stage_t cd_last;
  logic signed [20:0] nu_s, nv_s;
  logic [18:0] nu_c, nv_c;

  assign cd_last = cd_q[CORDIC_STEPS - 1];
  assign nu_s = 21'(FX_PI) + 21'(cd_last.th.ang);
  assign nv_s = 21'(FX_HALF_PI) - 21'(cd_last.ph.ang);

  always_comb begin
    if (nu_s < 0) begin
      nu_c = '0;
    end else if (nu_s > 21'(FX_TWO_PI)) begin
      nu_c = 19'(FX_TWO_PI);
    end else begin
      nu_c = nu_s[18:0];
    end
    if (nv_s < 0) begin
      nv_c = '0;
    end else if (nv_s > 21'(FX_PI)) begin
      nv_c = 19'(FX_PI);
    end else begin
      nv_c = nv_s[18:0];
    end
  end

  logic p1_vld_r, p1_ok_r;
  logic [18:0] p1_nu_r, p1_nv_r;
  logic p2_vld_r, p2_ok_r;
  logic [18:0] p2_nu_r, p2_nv_r;
  logic [41:0] p2_mu_r, p2_mv_r;
  logic p3_vld_r, p3_ok_r;
  logic [18:0] p3_nu_r, p3_nv_r;
  logic [20:0] p3_qu_r, p3_qv_r;
  logic [39:0] p3_pu_r, p3_pv_r;
  logic p4_vld_r, p4_ok_r;
  logic [20:0] p4_su_r, p4_sv_r;
  logic p5_vld_r, p5_ok_r;
  logic [35:0] p5_xw_r, p5_yh_r;
  logic p6_vld_r, p6_ok_r;
  logic [13:0] p6_px_r, p6_py_r;
  logic p7_vld_r, p7_ok_r;
  logic [13:0] p7_px_r, p7_py_r;
  logic [28:0] p7_yw_r;
  logic out_vld_r;
  logic [13:0] out_x_r, out_y_r;
  logic [29:0] out_off_r;

  logic [20:0] qu0, qv0;
  logic [39:0] remu, remv;
  logic [15:0] tx, ty;
  logic [29:0] addr_sum;

  assign qu0  = p2_mu_r[39:19];
  assign qv0  = p2_mv_r[39:19];
  assign remu = {1'b0, p3_nu_r, 20'b0} - p3_pu_r;
  assign remv = {1'b0, p3_nv_r, 20'b0} - p3_pv_r;
  assign tx   = p5_xw_r[35:20];
  assign ty   = p5_yh_r[35:20];
  assign addr_sum = 30'(p7_yw_r) + 30'(p7_px_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      cd_in_r.vld <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
      p5_vld_r  <= 1'b0;
      p6_vld_r  <= 1'b0;
      p7_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      cd_in_r   <= cd_in_nxt;
      p1_vld_r  <= cd_last.vld;
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      p4_vld_r  <= p3_vld_r;
      p5_vld_r  <= p4_vld_r;
      p6_vld_r  <= p5_vld_r;
      p7_vld_r  <= p6_vld_r;
      out_vld_r <= p7_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok_r <= ok_nxt;
      s1_x_r  <= x_nxt;
      s1_y_r  <= y_nxt;
      s1_z_r  <= z_nxt;

      s2_ok_r <= s1_ok_r;
      s2_x_r  <= s1_x_r;
      s2_y_r  <= s1_y_r;
      s2_z_r  <= s1_z_r;
      s2_xx_r <= xx_full[33:0];
      s2_zz_r <= zz_full[33:0];

      p1_ok_r <= cd_last.face_ok;
      p1_nu_r <= nu_c;
      p1_nv_r <= nv_c;

      p2_ok_r <= p1_ok_r;
      p2_nu_r <= p1_nu_r;
      p2_nv_r <= p1_nv_r;
      p2_mu_r <= p1_nu_r * RECIP_U;
      p2_mv_r <= p1_nv_r * RECIP_V;

      p3_ok_r <= p2_ok_r;
      p3_nu_r <= p2_nu_r;
      p3_nv_r <= p2_nv_r;
      p3_qu_r <= qu0;
      p3_qv_r <= qv0;
      p3_pu_r <= qu0 * 19'(FX_TWO_PI);
      p3_pv_r <= qv0 * 19'(FX_PI);

      p4_ok_r <= p3_ok_r;
      p4_su_r <= (remu >= 40'(FX_TWO_PI)) ? p3_qu_r + 21'd1 : p3_qu_r;
      p4_sv_r <= (remv >= 40'(FX_PI)) ? p3_qv_r + 21'd1 : p3_qv_r;

      p5_ok_r <= p4_ok_r;
      p5_xw_r <= p4_su_r * w_r;
      p5_yh_r <= p4_sv_r * h_r;

      // Wrap: scaled value never exceeds the size, so equal means zero
      p6_ok_r <= p5_ok_r;
      p6_px_r <= (tx >= {1'b0, w_r}) ? 14'd0 : tx[13:0];
      p6_py_r <= (ty >= {1'b0, h_r}) ? 14'd0 : ty[13:0];

      p7_ok_r <= p6_ok_r;
      p7_px_r <= p6_px_r;
      p7_py_r <= p6_py_r;
      p7_yw_r <= p6_py_r * w_r;

      out_x_r   <= p7_ok_r ? p7_px_r : 14'd0;
      out_y_r   <= p7_ok_r ? p7_py_r : 14'd0;
      out_off_r <= p7_ok_r ? {addr_sum[27:0], 2'b00} : 30'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_off_r, out_y_r, out_x_r};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import e2c_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [14:0] cfg_data;

  localparam int PIPE_DRAIN  = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 92;

  // Directed stimulus row; expected values typed in only where chk is set
  typedef struct {
    logic [2:0]  face;
    logic [9:0]  row;
    logic [9:0]  col;
    bit          chk;
    logic [63:0] ex;
  } vec_row_t;

  logic [63:0] addr_q[$];
  logic [14:0] width_reg;
  logic [14:0] height_reg;
  int          mismatches;
  int          cycles;
  int          tx_idle;
  int          rx_idle;
  bit          use_typed;
  logic [63:0] typed_ex;

  equirect_to_cubemap_address DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Vectoring CORDIC, atan2(b, a) in Q16 radians
  function automatic longint angle_q16(input longint b_in, input longint a_in);
    longint a;
    longint b;
    longint ang;
    longint da;
    longint db;
    longint tab[16];
    tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    a = a_in * 256;
    b = b_in * 256;
    ang = 0;
    if (a < 0) begin
      ang = (b >= 0) ? FX_PI : -FX_PI;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < 16; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b < 0) begin
        a = a - da;
        b = b + db;
        ang = ang - tab[i];
      end else begin
        a = a + da;
        b = b - db;
        ang = ang + tab[i];
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n_in);
    longint unsigned n;
    longint unsigned res;
    longint unsigned bitv;
    n = n_in;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint face_centre(input logic [9:0] idx);
    longint unsigned c;
    c = (idx >= FACE_TEXELS) ? FACE_TEXELS - 1 : idx;
    return longint'(((2 * c + 1) * FX_ONE) / FACE_TEXELS);
  endfunction

  function automatic longint unsigned clamp_size(input logic [14:0] s);
    if (s == 0) return 1;
    if (s > SIZE_MAX) return SIZE_MAX;
    return s;
  endfunction

  // Source texel address for one destination texel
  function automatic logic [63:0] source_addr(input logic [23:0] d);
    logic [2:0] face;
    longint u, v, x, y, z, theta, phi, nu, nv;
    longint unsigned r, su, sv, w, h, px, py;
    logic [63:0] res;
    face = d[2:0];
    u = face_centre(d[22:13]) - FX_ONE;
    v = FX_ONE - face_centre(d[12:3]);
    res = '0;
    case (face)
      3'd0: begin x = FX_ONE;  y = v;       z = -u;      end
      3'd1: begin x = -FX_ONE; y = v;       z = u;       end
      3'd2: begin x = u;       y = FX_ONE;  z = -v;      end
      3'd3: begin x = u;       y = -FX_ONE; z = v;       end
      3'd4: begin x = u;       y = v;       z = FX_ONE;  end
      3'd5: begin x = -u;      y = v;       z = -FX_ONE; end
      default: return res;
    endcase
    theta = angle_q16(x, z);
    r = int_sqrt(longint'(x * x) + longint'(z * z));
    phi = angle_q16(y, longint'(r));
    nu = FX_PI + theta;
    if (nu < 0) nu = 0;
    if (nu > FX_TWO_PI) nu = FX_TWO_PI;
    nv = FX_HALF_PI - phi;
    if (nv < 0) nv = 0;
    if (nv > FX_PI) nv = FX_PI;
    su = (longint'(nu) << 20) / FX_TWO_PI;
    sv = (longint'(nv) << 20) / FX_PI;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    px = ((su * w) >> 20) % w;
    py = ((sv * h) >> 20) % h;
    res[13:0]  = px[13:0];
    res[27:14] = py[13:0];
    res[57:28] = 30'((py * w + px) * 4);
    return res;
  endfunction

  // Monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin
    logic [63:0] ex;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      // Typed-in rows replace the prediction
      if (in_tvalid && in_tready)
        addr_q.push_back(use_typed ? typed_ex : source_addr(in_tdata));
      if (out_tvalid && out_tready) begin
        if (addr_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          ex = addr_q.pop_front();
          if (out_tdata[13:0] !== ex[13:0] || out_tdata[27:14] !== ex[27:14] ||
              out_tdata[57:28] !== ex[57:28]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch x/y/off exp %0d/%0d/%0d got %0d/%0d/%0d",
                       ex[13:0], ex[27:14], ex[57:28],
                       out_tdata[13:0], out_tdata[27:14], out_tdata[57:28]);
          end
        end
      end
    end
  end

  // Result side stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic send_texel(input logic [23:0] d);
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (addr_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [23:0] pack_texel(input logic [2:0] f, input logic [9:0] r,
                                             input logic [9:0] c);
    return {1'b0, c, r, f};
  endfunction

  vec_row_t    directed[$];
  logic [14:0] widths[6];
  logic [14:0] heights[6];

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_SOURCE_WIDTH; cfg_data = '0;
    width_reg = 15'd2048; height_reg = 15'd1024;
    mismatches = 0; cycles = 0; tx_idle = 0; rx_idle = 0;
    use_typed = 1'b0; typed_ex = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: face centers and corners, invalid faces give all zeros
    for (int f = 0; f < 6; f++) begin
      directed.push_back('{3'(f), 10'd511, 10'd512, 1'b0, '0});
      directed.push_back('{3'(f), 10'd0, 10'd0, 1'b0, '0});
      directed.push_back('{3'(f), 10'd1023, 10'd1023, 1'b0, '0});
    end
    directed.push_back('{3'd6, 10'd5, 10'd7, 1'b1, 64'd0});
    directed.push_back('{3'd7, 10'd1023, 10'd1023, 1'b1, 64'd0});
    directed.push_back('{3'd4, 10'd0, 10'd1023, 1'b0, '0});
    directed.push_back('{3'd5, 10'd1023, 10'd0, 1'b0, '0});
    foreach (directed[i]) begin
      use_typed = directed[i].chk;
      typed_ex  = directed[i].ex;
      send_texel(pack_texel(directed[i].face, directed[i].row, directed[i].col));
    end
    use_typed = 1'b0;
    drain_results();

    // Random phases: size settings include the extremes and out-of-range values
    widths  = '{15'd0, 15'd16384, 15'd1, 15'd32767, 15'd16385, 15'($urandom_range(32767))};
    heights = '{15'd0, 15'd16384, 15'd32767, 15'd1, 15'd3, 15'($urandom_range(32767))};
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin tx_idle = 30; rx_idle = 61; end
        1: begin tx_idle = 61; rx_idle = 30; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      write_reg(REG_SOURCE_WIDTH, widths[p]);
      write_reg(REG_SOURCE_HEIGHT, heights[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 40) drain_results();
        send_texel(24'($urandom_range(24'h7FFFFF)));
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
